### sv/nsv_pkg.sv
`default_nettype none

package nsv_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [7:0] RESET_MAX_LENGTH = 8'd82;
    localparam logic [4:0] RESET_MIN_FIELDS = 5'd11;
    localparam logic [4:0] RESET_MAX_FIELDS = 5'd15;

    localparam logic [7:0] HDR_POS_FIRST = 8'd3;
    localparam logic [7:0] HDR_DONE_POS  = 8'd6;
    localparam logic [7:0] MIN_TYPED_LEN = 8'd7;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
    localparam logic [1:0] REG_MIN_FIELDS = 2'd1;
    localparam logic [1:0] REG_MAX_FIELDS = 2'd2;

    typedef enum logic [1:0] {
        TYPE_UNKNOWN = 2'd0,
        TYPE_GGA     = 2'd1,
        TYPE_RMC     = 2'd2
    } sent_type_t;

    typedef enum logic [2:0] {
        ST_VALID       = 3'd0,
        ST_BAD_HEADER  = 3'd1,
        ST_TOO_LONG    = 3'd2,
        ST_FIELD_COUNT = 3'd3,
        ST_CHECKSUM    = 3'd4
    } status_t;

    typedef struct packed {
        logic        in_sentence;
        logic        after_star;
        logic [7:0]  byte_count;
        logic [7:0]  running_xor;
        logic [4:0]  comma_count;
        logic [1:0]  type_match;   // bit 0 GGA possible, bit 1 RMC possible
        logic [15:0] sum_digits;
        logic [1:0]  digit_count;
    } state_t;

    typedef struct packed {
        logic [7:0] max_length;
        logic [4:0] min_fields;
        logic [4:0] max_fields;
    } cfg_t;

    typedef struct packed {
        sent_type_t sentence_type;
        status_t    status;
        logic [7:0] computed_sum;
        logic [4:0] fields_seen;
        logic [7:0] sentence_length;
    } result_t;

    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h37 + {4'd0, nib};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/nsv_step.sv
`default_nettype none

module nsv_step (
    input  wire logic [7:0]      rx_byte,
    input  wire nsv_pkg::state_t cur,
    input  wire nsv_pkg::cfg_t   cfg,
    output nsv_pkg::state_t      nxt,
    output logic                 emit,
    output nsv_pkg::result_t     res
);

    logic [7:0] pos;
    logic [7:0] count_inc;
    logic [4:0] fields;
    logic       hdr_done;
    logic [7:0] exp_gga;
    logic [7:0] exp_rmc;
    logic       in_hdr;
    logic       sum_ok;

    assign pos       = cur.byte_count;
    assign count_inc = (cur.byte_count == 8'hFF) ? cur.byte_count : cur.byte_count + 8'd1;
    assign fields    = (cur.comma_count == 5'h1F) ? cur.comma_count : cur.comma_count + 5'd1;
    assign hdr_done  = (pos >= nsv_pkg::HDR_DONE_POS);
    assign sum_ok    = (cur.digit_count == 2'd2)
                    && (cur.sum_digits[15:8] == nsv_pkg::hex_upper(cur.running_xor[7:4]))
                    && (cur.sum_digits[7:0] == nsv_pkg::hex_upper(cur.running_xor[3:0]));

    always_comb begin
        in_hdr  = 1'b1;
        exp_gga = 8'h00;
        exp_rmc = 8'h00;
        unique case (pos)
            8'd3: begin
                exp_gga = "G";
                exp_rmc = "R";
            end
            8'd4: begin
                exp_gga = "G";
                exp_rmc = "M";
            end
            8'd5: begin
                exp_gga = "A";
                exp_rmc = "C";
            end
            default: begin
                in_hdr = 1'b0;
            end
        endcase
    end

    always_comb begin
        nxt  = cur;
        emit = 1'b0;

        res.computed_sum    = cur.running_xor;
        res.fields_seen     = fields;
        res.sentence_length = count_inc;
        if (hdr_done && cur.type_match[0]) begin
            res.sentence_type = nsv_pkg::TYPE_GGA;
        end else if (hdr_done && cur.type_match[1]) begin
            res.sentence_type = nsv_pkg::TYPE_RMC;
        end else begin
            res.sentence_type = nsv_pkg::TYPE_UNKNOWN;
        end
        priority if (res.sentence_type == nsv_pkg::TYPE_UNKNOWN) begin
            res.status = nsv_pkg::ST_BAD_HEADER;
        end else if (count_inc > cfg.max_length) begin
            res.status = nsv_pkg::ST_TOO_LONG;
        end else if (fields < cfg.min_fields || fields > cfg.max_fields) begin
            res.status = nsv_pkg::ST_FIELD_COUNT;
        end else if (!sum_ok) begin
            res.status = nsv_pkg::ST_CHECKSUM;
        end else begin
            res.status = nsv_pkg::ST_VALID;
        end

        if (rx_byte == nsv_pkg::CH_DOLLAR) begin
            nxt.in_sentence = 1'b1;
            nxt.after_star  = 1'b0;
            nxt.byte_count  = 8'd1;
            nxt.running_xor = 8'd0;
            nxt.comma_count = 5'd0;
            nxt.type_match  = 2'b11;
            nxt.sum_digits  = 16'd0;
            nxt.digit_count = 2'd0;
        end else if (cur.in_sentence) begin
            nxt.byte_count = count_inc;
            if (rx_byte == nsv_pkg::CH_LF) begin
                emit            = 1'b1;
                nxt.in_sentence = 1'b0;
            end else begin
                if (in_hdr) begin
                    if (rx_byte != exp_gga) begin
                        nxt.type_match[0] = 1'b0;
                    end
                    if (rx_byte != exp_rmc) begin
                        nxt.type_match[1] = 1'b0;
                    end
                end
                if (cur.after_star) begin
                    if (cur.digit_count == 2'd0) begin
                        nxt.sum_digits  = {rx_byte, 8'd0};
                        nxt.digit_count = 2'd1;
                    end else if (cur.digit_count == 2'd1) begin
                        nxt.sum_digits  = {cur.sum_digits[15:8], rx_byte};
                        nxt.digit_count = 2'd2;
                    end
                end else if (rx_byte == nsv_pkg::CH_STAR) begin
                    nxt.after_star = 1'b1;
                end else begin
                    nxt.running_xor = cur.running_xor ^ rx_byte;
                    if (rx_byte == nsv_pkg::CH_COMMA && cur.comma_count != 5'h1F) begin
                        nxt.comma_count = cur.comma_count + 5'd1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/nmea_sentence_validator.sv
`default_nettype none

// channel   direction  ports
// s_        in         s_valid, s_ready, s_rx_byte
// m_        out        m_valid, m_ready, m_sentence_type, m_status, m_computed_sum,
//                      m_fields_seen, m_sentence_length
// apb       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One item per cycle sustained while no result is stalled. A byte sits in the input
// register, is folded into the sentence state, and a line feed loads the result
// register together with m_valid.
// Synchronous active-low reset clears sentence state and handshake flags; the
// registers return to 82 / 11 / 15. A stalled result holds only a byte in the
// input register; s_ready stays high while the result register is free.

module nmea_sentence_validator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_sentence_type,
    output logic [2:0]       m_status,
    output logic [7:0]       m_computed_sum,
    output logic [4:0]       m_fields_seen,
    output logic [7:0]       m_sentence_length,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    nsv_pkg::state_t  state_reg;
    nsv_pkg::state_t  state_next;
    nsv_pkg::cfg_t    cfg_reg;
    logic             m_valid_reg;
    nsv_pkg::result_t result_reg;
    nsv_pkg::result_t result_next;
    logic             emit;
    logic             advance;
    logic             cfg_wr;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    nsv_step u_step (
        .rx_byte (in_byte_reg),
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .nxt     (state_next),
        .emit    (emit),
        .res     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && emit) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_length <= nsv_pkg::RESET_MAX_LENGTH;
            cfg_reg.min_fields <= nsv_pkg::RESET_MIN_FIELDS;
            cfg_reg.max_fields <= nsv_pkg::RESET_MAX_FIELDS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                nsv_pkg::REG_MAX_LENGTH: cfg_reg.max_length <= pwdata[7:0];
                nsv_pkg::REG_MIN_FIELDS: cfg_reg.min_fields <= pwdata[4:0];
                nsv_pkg::REG_MAX_FIELDS: cfg_reg.max_fields <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            nsv_pkg::REG_MAX_LENGTH: prdata = {24'd0, cfg_reg.max_length};
            nsv_pkg::REG_MIN_FIELDS: prdata = {27'd0, cfg_reg.min_fields};
            nsv_pkg::REG_MAX_FIELDS: prdata = {27'd0, cfg_reg.max_fields};
            default:                 prdata = 32'd0;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_sentence_type   = result_reg.sentence_type;
    assign m_status          = result_reg.status;
    assign m_computed_sum    = result_reg.computed_sum;
    assign m_fields_seen     = result_reg.fields_seen;
    assign m_sentence_length = result_reg.sentence_length;

endmodule

`default_nettype wire

### sv/nsv_checker.sv
`default_nettype none

module nsv_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_sentence_type,
    input wire logic [2:0] m_status,
    input wire logic [7:0] m_computed_sum,
    input wire logic [7:0] m_sentence_length
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_computed_sum))
        else $error("stalled item changed");

    a_free_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_typed_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sentence_type != nsv_pkg::TYPE_UNKNOWN
            |-> m_sentence_length >= nsv_pkg::MIN_TYPED_LEN)
        else $error("typed sentence too short");

    a_valid_typed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == nsv_pkg::ST_VALID
            |-> m_sentence_type != nsv_pkg::TYPE_UNKNOWN)
        else $error("valid status without type");

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_sentence_type   (m_sentence_type),
    .m_status          (m_status),
    .m_computed_sum    (m_computed_sum),
    .m_sentence_length (m_sentence_length)
);

`default_nettype wire
